// File: rtl/core/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// types, character codes and decode helpers shared by the escape decoder
// ----------------------------------------------------------------------------
package sed_pkg;

    // command codes of an input item
    localparam logic CMD_BODY = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // characters with a meaning to the decoder
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // digits per escape
    localparam logic [2:0] HEX_DIGITS = 3'd4;
    localparam logic [2:0] OCT_DIGITS = 3'd3;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_OCT   = 3'd3,
        MODE_ERR   = 3'd4
    } t_mode;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic       error;
    } t_out_item;

    // one accepted input item after classification: one or two results
    typedef struct packed {
        t_out_item res0;
        t_out_item res1;
        logic      two;
    } t_work;

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

    // {hit, byte} for the single-character escapes
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:     r = {1'b1, 8'd7};
            8'h62:     r = {1'b1, 8'd8};
            8'h66:     r = {1'b1, 8'd12};
            8'h6e:     r = {1'b1, 8'd10};
            8'h72:     r = {1'b1, 8'd13};
            8'h74:     r = {1'b1, 8'd9};
            8'h76:     r = {1'b1, 8'd11};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/sed_front.sv
// ----------------------------------------------------------------------------
// sed_front
// decode state machine: classifies each accepted item into zero to two results
// ----------------------------------------------------------------------------
module sed_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sed_pkg::t_in_item i_item,
    output logic              o_wr,
    output sed_pkg::t_work    o_work
);

    sed_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_acc, n_acc;
    logic [2:0]     r_cnt, n_cnt;

    logic [7:0] c;
    logic [4:0] hex;
    logic [8:0] simple;
    logic [2:0] cnt_inc;

    assign c       = i_item.data_byte;
    assign hex     = sed_pkg::hex_digit(c);
    assign simple  = sed_pkg::simple_escape(c);
    assign cnt_inc = r_cnt + 3'd1;

    // next state
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        if (i_accept) begin
            if (i_item.command == sed_pkg::CMD_END) begin
                n_mode = sed_pkg::MODE_PLAIN;
                n_acc  = 8'd0;
                n_cnt  = 3'd0;
            end else begin
                case (r_mode)
                    sed_pkg::MODE_ESC: begin
                        if (simple[8]) begin
                            n_mode = sed_pkg::MODE_PLAIN;
                        end else if (c == sed_pkg::CH_U) begin
                            n_mode = sed_pkg::MODE_HEX;
                            n_acc  = 8'd0;
                            n_cnt  = 3'd0;
                        end else if (sed_pkg::is_octal(c)) begin
                            n_mode = sed_pkg::MODE_OCT;
                            n_acc  = {5'd0, c[2:0]};
                            n_cnt  = 3'd1;
                        end else begin
                            n_mode = sed_pkg::MODE_ERR;
                        end
                    end
                    sed_pkg::MODE_HEX: begin
                        if (!hex[4]) begin
                            n_mode = sed_pkg::MODE_ERR;
                        end else if (cnt_inc == sed_pkg::HEX_DIGITS) begin
                            n_mode = sed_pkg::MODE_PLAIN;
                            n_acc  = 8'd0;
                            n_cnt  = 3'd0;
                        end else begin
                            n_acc = {r_acc[3:0], hex[3:0]};
                            n_cnt = cnt_inc;
                        end
                    end
                    sed_pkg::MODE_OCT: begin
                        if (sed_pkg::is_octal(c) && cnt_inc != sed_pkg::OCT_DIGITS) begin
                            n_acc = {r_acc[4:0], c[2:0]};
                            n_cnt = cnt_inc;
                        end else begin
                            n_mode = (!sed_pkg::is_octal(c) && c == sed_pkg::CH_BSLASH)
                                   ? sed_pkg::MODE_ESC : sed_pkg::MODE_PLAIN;
                            n_acc  = 8'd0;
                            n_cnt  = 3'd0;
                        end
                    end
                    sed_pkg::MODE_ERR: begin
                        n_mode = sed_pkg::MODE_ERR;
                    end
                    default: begin
                        n_mode = (c == sed_pkg::CH_BSLASH) ? sed_pkg::MODE_ESC
                                                           : sed_pkg::MODE_PLAIN;
                    end
                endcase
            end
        end
    end

    // results of the accepted item
    always_comb begin
        o_wr          = 1'b0;
        o_work        = '0;
        if (i_accept) begin
            if (i_item.command == sed_pkg::CMD_END) begin
                o_wr = 1'b1;
                case (r_mode)
                    sed_pkg::MODE_OCT: begin
                        o_work.res0 = '{out_byte: r_acc, byte_valid: 1'b1,
                                        done_res: 1'b0, error: 1'b0};
                        o_work.res1 = '{out_byte: 8'd0, byte_valid: 1'b0,
                                        done_res: 1'b1, error: 1'b0};
                        o_work.two  = 1'b1;
                    end
                    sed_pkg::MODE_ESC, sed_pkg::MODE_HEX, sed_pkg::MODE_ERR: begin
                        o_work.res0 = '{out_byte: 8'd0, byte_valid: 1'b0,
                                        done_res: 1'b1, error: 1'b1};
                    end
                    default: begin
                        o_work.res0 = '{out_byte: 8'd0, byte_valid: 1'b0,
                                        done_res: 1'b1, error: 1'b0};
                    end
                endcase
            end else begin
                case (r_mode)
                    sed_pkg::MODE_ESC: begin
                        o_wr        = simple[8];
                        o_work.res0 = '{out_byte: simple[7:0], byte_valid: 1'b1,
                                        done_res: 1'b0, error: 1'b0};
                    end
                    sed_pkg::MODE_HEX: begin
                        o_wr        = hex[4] && (cnt_inc == sed_pkg::HEX_DIGITS);
                        o_work.res0 = '{out_byte: {r_acc[3:0], hex[3:0]}, byte_valid: 1'b1,
                                        done_res: 1'b0, error: 1'b0};
                    end
                    sed_pkg::MODE_OCT: begin
                        o_wr = 1'b1;
                        if (sed_pkg::is_octal(c)) begin
                            // third digit closes the escape
                            o_wr        = (cnt_inc == sed_pkg::OCT_DIGITS);
                            o_work.res0 = '{out_byte: {r_acc[4:0], c[2:0]}, byte_valid: 1'b1,
                                            done_res: 1'b0, error: 1'b0};
                        end else begin
                            // flush value, then plain byte unless a backslash
                            o_work.res0 = '{out_byte: r_acc, byte_valid: 1'b1,
                                            done_res: 1'b0, error: 1'b0};
                            o_work.res1 = '{out_byte: c, byte_valid: 1'b1,
                                            done_res: 1'b0, error: 1'b0};
                            o_work.two  = (c != sed_pkg::CH_BSLASH);
                        end
                    end
                    sed_pkg::MODE_ERR: begin
                        o_wr = 1'b0;
                    end
                    default: begin
                        o_wr        = (c != sed_pkg::CH_BSLASH);
                        o_work.res0 = '{out_byte: c, byte_valid: 1'b1,
                                        done_res: 1'b0, error: 1'b0};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sed_pkg::MODE_PLAIN;
            r_acc  <= 8'd0;
            r_cnt  <= 3'd0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: rtl/core/sed_queue.sv
// ----------------------------------------------------------------------------
// sed_queue
// small register queue of classified items between front and back
// ----------------------------------------------------------------------------
module sed_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  sed_pkg::t_work i_wdata,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_rd,
    output sed_pkg::t_work o_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sed_pkg::t_work   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!do_wr && do_rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// File: rtl/core/sed_back.sv
// ----------------------------------------------------------------------------
// sed_back
// unpacks classified items into single results behind an output register
// ----------------------------------------------------------------------------
module sed_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sed_pkg::t_work     i_work,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output sed_pkg::t_out_item o_item
);

    logic               r_out_valid, n_out_valid;
    logic               r_pend_valid, n_pend_valid;
    sed_pkg::t_out_item r_out, n_out;
    sed_pkg::t_out_item r_pend, n_pend;
    logic               slot_free;

    assign slot_free = !r_out_valid || i_pop;
    assign o_take    = slot_free && !r_pend_valid && i_valid;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_pend       = r_pend;
        if (slot_free) begin
            if (r_pend_valid) begin
                // second result of the last item goes first
                n_out        = r_pend;
                n_out_valid  = 1'b1;
                n_pend_valid = 1'b0;
            end else if (i_valid) begin
                n_out        = i_work.res0;
                n_pend       = i_work.res1;
                n_out_valid  = 1'b1;
                n_pend_valid = i_work.two;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

endmodule

// File: rtl/core/string_escape_decoder.sv
// ----------------------------------------------------------------------------
// string_escape_decoder
// unescapes quoted string body bytes; unless stalled, one transfer per cycle
// ----------------------------------------------------------------------------
// The block takes the body bytes of a quoted string, then an end command,
// and gives the unescaped bytes followed by one done result whose error bit
// tells whether the string held a malformed escape (in that case the bytes
// already given for the string are to be discarded). Both sides look like a
// queue: an input transfer happens when push is high and full is low, a
// result transfer when pop is high and empty is low. While neither side
// stalls, the block takes one input transfer per cycle and gives one
// result per cycle; an item gives zero, one or two results, and an item
// with two results (an octal escape flushed by the end command or by a
// following byte other than a backslash) holds the result side for both.
// The queue of QUEUE_DEPTH classified items between the decoder and the
// output register absorbs that, so full only rises when the result side
// is stalled or two-result items come in a long run.
// ----------------------------------------------------------------------------
module string_escape_decoder #(
    parameter int QUEUE_DEPTH = 4   // classified items buffered, at least 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sed_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output sed_pkg::t_out_item o_out_item
);

    logic           accept;     // input transfer this cycle
    logic           wr;         // item produces at least one result
    sed_pkg::t_work work;
    logic           q_full;
    logic           q_valid;
    logic           q_take;
    sed_pkg::t_work q_work;

    assign full   = q_full;
    assign accept = push && !q_full;

    // front: escape state machine
    sed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_wr     (wr),
        .o_work   (work)
    );

    // queue between decoder and result side
    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_wdata (work),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_rd    (q_take),
        .o_rdata (q_work)
    );

    // back: one result per transfer
    sed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_work  (q_work),
        .o_take  (q_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_out_item)
    );

endmodule

// File: rtl/core/sed_checker.sv
// ----------------------------------------------------------------------------
// sed_checker
// port-level checks of the escape decoder's result side
// ----------------------------------------------------------------------------
module sed_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input sed_pkg::t_in_item  i_in_item,
    input logic               empty,
    input logic               pop,
    input sed_pkg::t_out_item o_out_item
);

    logic unused_in;
    assign unused_in = push ^ full ^ (^i_in_item);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("stalled result changed");

    // every result is a byte or a done
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.byte_valid != o_out_item.done_res))
        else $error("result is neither byte nor done");

    // done results carry no byte
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.done_res) |-> (o_out_item.out_byte == 8'd0))
        else $error("done result carries a byte");

    // error only on done
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.error) |-> o_out_item.done_res)
        else $error("error flag on a byte result");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .i_in_item  (i_in_item),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);
